/* sv/pntp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_pkg
// Shared types, constants and the digit decoder of the number token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pntp_pkg;

  // Default values of the top-level parameters.
  localparam int CELL_WIDTH_DEF = 32;
  localparam int MAX_BASE_DEF   = 36;

  // Fixed field widths.
  localparam int CH_W    = 8;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 32;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_DEFAULT_BASE = APB_ADDR_W'(0);

  // Base values.
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;

  // Prefix characters.
  localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CH_W-1:0] CH_HASH    = 8'h23;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;

  // Character classes.
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CH_W-1:0] CASE_BIT   = 8'h20;
  localparam logic [CH_W-1:0] ALPHA_OFS  = 8'h57;

  // One item held in the input register.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic            token_end;
  } item_t;

  // Decoded digit.
  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] d;
  } digit_t;

  // Folds A-Z to lower case and maps 0-9a-z to 0..35, limited to max_base symbols.
  function automatic digit_t digit_of(input logic [CH_W-1:0] c, input int max_base);
    logic [CH_W-1:0] lc;
    logic [CH_W-1:0] raw;
    digit_t          res;
    lc  = c;
    raw = '0;
    res = '0;
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      lc = c | CASE_BIT;
    end
    if (lc inside {[CH_ZERO:CH_NINE]}) begin
      raw    = lc - CH_ZERO;
      res.ok = 1'b1;
    end else if (lc inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      raw    = lc - ALPHA_OFS;
      res.ok = 1'b1;
    end
    res.d = raw[BASE_W-1:0];
    if (int'(raw) >= max_base) begin
      res.ok = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/pntp_char_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_char_if
// Character channel: one token character or an end marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pntp_char_if;
  import pntp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            token_end;

  modport source (output valid, output ch, output token_end, input ready);
  modport sink   (input valid, input ch, input token_end, output ready);
endinterface

`default_nettype wire

/* sv/pntp_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_result_if
// Result channel: one parsed token per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pntp_result_if;
  import pntp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      is_number;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output is_number, output value, input ready);
  modport sink   (input valid, input is_number, input value, output ready);
endinterface

`default_nettype wire

/* sv/pntp_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_apb_regs
// APB register file holding the default numeric base.
// ----------------------------------------------------------------------------
`default_nettype none

module pntp_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pntp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [pntp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [pntp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic      [pntp_pkg::BASE_W-1:0]      default_base
);
  import pntp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_DEFAULT_BASE);

  // Register write at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_base <= BASE_RESET;
    end else if (wr_en) begin
      default_base <= pwdata[BASE_W-1:0];
    end
  end

  // Read data decode.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_DEFAULT_BASE) begin
      prdata = {{(APB_DATA_W-BASE_W){1'b0}}, default_base};
    end
  end

endmodule

`default_nettype wire

/* sv/pntp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_in_stage
// Input register: holds one character transfer until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pntp_in_stage (
  input  wire logic    clk,
  input  wire logic    rst,
  pntp_char_if.sink    chars,
  input  wire logic    advance,
  output pntp_pkg::item_t item
);
  import pntp_pkg::*;

  logic take;

  // The register is free when empty or when its item moves on this cycle.
  assign chars.ready = !item.valid || advance;
  assign take        = chars.valid && chars.ready;

  // Valid flag with reset; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (take) begin
      item.valid <= 1'b1;
    end else if (advance) begin
      item.valid <= 1'b0;
    end
    if (take) begin
      item.ch        <= chars.ch;
      item.token_end <= chars.token_end;
    end
  end

endmodule

`default_nettype wire

/* sv/pntp_token_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntp_token_state
// Token state, digit accumulation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pntp_token_state #(
  parameter int CELL_WIDTH = pntp_pkg::CELL_WIDTH_DEF,
  parameter int MAX_BASE   = pntp_pkg::MAX_BASE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [pntp_pkg::BASE_W-1:0]  default_base,
  input  wire pntp_pkg::item_t              item,
  output logic                              advance,
  pntp_result_if.source                     results
);
  import pntp_pkg::*;

  // Token state.
  logic                    at_first_char, at_first_char_next;
  logic [BASE_W-1:0]       active_base, active_base_next;
  logic                    negate_flag, negate_flag_next;
  logic [CELL_WIDTH-1:0]   accumulator, accumulator_next;
  logic                    bad_char_seen, bad_char_seen_next;

  // Result register.
  logic                      res_valid;
  logic                      res_is_number;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_is_number_next;
  logic signed [VALUE_W-1:0] res_value_next;
  logic                      load_result;

  // Digit path.
  logic [BASE_W-1:0]          use_base;
  logic                       do_digit;
  digit_t                     dig;
  logic [CELL_WIDTH+BASE_W-1:0] product;
  logic [CELL_WIDTH-1:0]      signed_acc;

  // An end marker waits until the result register is free.
  assign advance     = item.valid && (!item.token_end || !res_valid || results.ready);
  assign load_result = advance && item.token_end;

  assign dig     = digit_of(item.ch, MAX_BASE);
  assign product = {{BASE_W{1'b0}}, accumulator} * {{CELL_WIDTH{1'b0}}, use_base};

  // Signed value of the finished token.
  assign signed_acc = negate_flag ? (CELL_WIDTH'(0) - accumulator) : accumulator;

  // Next state for the item at the head of the input register.
  always_comb begin
    at_first_char_next = at_first_char;
    active_base_next   = active_base;
    negate_flag_next   = negate_flag;
    accumulator_next   = accumulator;
    bad_char_seen_next = bad_char_seen;
    use_base           = active_base;
    do_digit           = 1'b0;
    res_is_number_next = !bad_char_seen;
    res_value_next     = '0;
    if (!bad_char_seen) begin
      res_value_next = VALUE_W'(signed'(signed_acc));
    end

    if (item.token_end) begin
      at_first_char_next = 1'b1;
      active_base_next   = default_base;
      negate_flag_next   = 1'b0;
      accumulator_next   = '0;
      bad_char_seen_next = 1'b0;
    end else if (at_first_char) begin
      at_first_char_next = 1'b0;
      active_base_next   = default_base;
      use_base           = default_base;
      case (item.ch)
        CH_DOLLAR:  active_base_next = BASE_HEX;
        CH_PERCENT: active_base_next = BASE_BIN;
        CH_HASH:    active_base_next = BASE_DEC;
        CH_MINUS:   negate_flag_next = 1'b1;
        default:    do_digit         = !bad_char_seen;
      endcase
    end else begin
      do_digit = !bad_char_seen;
    end

    // Digit accepted only below the active base; anything else spoils the token.
    if (do_digit) begin
      if (!dig.ok || (dig.d >= use_base)) begin
        bad_char_seen_next = 1'b1;
      end else begin
        accumulator_next = product[CELL_WIDTH-1:0]
                         + {{(CELL_WIDTH-BASE_W){1'b0}}, dig.d};
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_char <= 1'b1;
      active_base   <= BASE_RESET;
      negate_flag   <= 1'b0;
      accumulator   <= '0;
      bad_char_seen <= 1'b0;
    end else if (advance) begin
      at_first_char <= at_first_char_next;
      active_base   <= active_base_next;
      negate_flag   <= negate_flag_next;
      accumulator   <= accumulator_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_result) begin
      res_is_number <= res_is_number_next;
      res_value     <= res_value_next;
    end
  end

  assign results.valid     = res_valid;
  assign results.is_number = res_is_number;
  assign results.value     = res_value;

endmodule

`default_nettype wire

/* sv/prefixed_number_token_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_number_token_parser_top
// Parses prefixed number literals arriving one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one token character per transfer; a transfer with
//   token_end set closes the token and asks for its result. The first
//   character may be '$' (hex), '%' (binary), '#' (decimal) or '-'
//   (negate, default base). results carries one transfer per closed token:
//   is_number and the two's-complement value (zero when not a number).
//   The default base is set over the APB port at byte address 0 and is
//   taken up when a token's first character is processed.
// Timing:
//   One character per cycle while no end transfer waits for the result
//   register. Each transfer is held in the input register, and the
//   multiply-add by the base updates the accumulator as it leaves. A
//   result's end transfer passes through the input register and then
//   loads the result register. The accumulator loop sets the rate.
// Reset and stalls:
//   rst clears both registers and restores base ten. While a result waits,
//   characters are still taken; only a further end transfer holds in the
//   input register, and chars.ready falls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prefixed_number_token_parser_top #(
  parameter int CELL_WIDTH = pntp_pkg::CELL_WIDTH_DEF,
  parameter int MAX_BASE   = pntp_pkg::MAX_BASE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pntp_char_if.sink                             chars,
  pntp_result_if.source                         results,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pntp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [pntp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [pntp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import pntp_pkg::*;

  logic [BASE_W-1:0] default_base;
  item_t             item;
  logic              advance;

  // Configuration registers.
  pntp_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .default_base (default_base)
  );

  // Input register.
  pntp_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .item    (item)
  );

  // Parser state and result register.
  pntp_token_state #(
    .CELL_WIDTH (CELL_WIDTH),
    .MAX_BASE   (MAX_BASE)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .default_base (default_base),
    .item         (item),
    .advance      (advance),
    .results      (results)
  );

endmodule

`default_nettype wire

/* tb/prefixed_number_token_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_number_token_parser_top_tb
// Self-checking bench for the prefixed number token parser.
// A directed set of tokens covers empty tokens, bare prefixes, every prefix,
// case folding, misplaced prefixes and out-of-range bytes. Random tokens then
// run under a series of default bases, the register extremes among them. An
// in-bench parser predicts each result and the result stream is compared
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module prefixed_number_token_parser_top_tb;
  import pntp_pkg::*;

  localparam int unsigned PHASE_ITEMS    = 50;
  localparam int unsigned PHASE_COUNT    = 9;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1500;
  localparam int unsigned DIGIT_SYMBOLS  = 36;

  // Parser predictor with the queue of results still owed by the block.
  class number_predictor;
    logic [BASE_W-1:0]  default_base;
    bit                 at_first;
    logic [BASE_W-1:0]  base;
    bit                 negate;
    logic [VALUE_W-1:0] acc;
    bit                 bad;
    bit                 due_is_number[$];
    logic [VALUE_W-1:0] due_value[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      default_base = BASE_RESET;
      errors       = 0;
      checked      = 0;
      restart();
    endfunction

    function void restart();
      at_first = 1'b1;
      base     = default_base;
      negate   = 1'b0;
      acc      = '0;
      bad      = 1'b0;
    endfunction

    task report(input string msg);
      $display("[%0t ns] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Applies one accepted character transfer to the predicted state.
    function void take_char(input logic [CH_W-1:0] c, input bit closes);
      logic [CH_W-1:0]    lc;
      logic [VALUE_W-1:0] v;
      int                 d;
      if (closes) begin
        v = '0;
        if (!bad) begin
          v = negate ? -acc : acc;
        end
        due_is_number.push_back(!bad);
        due_value.push_back(v);
        restart();
        return;
      end
      // The base is taken up when the first character arrives.
      if (at_first) begin
        at_first = 1'b0;
        base     = default_base;
        if (c == CH_DOLLAR) begin
          base = BASE_HEX;
          return;
        end
        if (c == CH_PERCENT) begin
          base = BASE_BIN;
          return;
        end
        if (c == CH_HASH) begin
          base = BASE_DEC;
          return;
        end
        if (c == CH_MINUS) begin
          negate = 1'b1;
          return;
        end
      end
      if (bad) begin
        return;
      end
      // Fold upper case, then map 0-9a-z to 0..35; all 36 symbols exist.
      lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
      d  = -1;
      if (lc >= CH_ZERO && lc <= CH_NINE) begin
        d = int'(lc - CH_ZERO);
      end else if (lc >= CH_LOWER_A && lc <= CH_LOWER_Z) begin
        d = int'(lc - CH_LOWER_A) + 10;
      end
      if (d < 0 || d >= int'(base)) begin
        bad = 1'b1;
      end else begin
        acc = acc * base + VALUE_W'(d);
      end
    endfunction

    // Compares one accepted result transfer with the oldest prediction.
    task match_result(input logic is_number, input logic [VALUE_W-1:0] value);
      bit                 want_num;
      logic [VALUE_W-1:0] want_val;
      if (due_value.size() == 0) begin
        report($sformatf("result (%b, %0d) with none outstanding", is_number,
                         $signed(value)));
        return;
      end
      want_num = due_is_number.pop_front();
      want_val = due_value.pop_front();
      checked++;
      if (is_number !== want_num) begin
        report($sformatf("result %0d: is_number %b, predicted %b", checked,
                         is_number, want_num));
      end
      if (value !== want_val) begin
        report($sformatf("result %0d: value %0d, predicted %0d", checked,
                         $signed(value), $signed(want_val)));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pntp_char_if   char_ch ();
  pntp_result_if result_ch ();

  number_predictor   parser_model = new();
  logic [BASE_W-1:0] cur_base = BASE_RESET;
  int unsigned       chars_sent = 0;
  bit                sender_no_idle = 1'b0;
  bit                receiver_no_idle = 1'b0;
  bit                long_hold_req = 1'b0;

  prefixed_number_token_parser_top u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch.sink),
    .results (result_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before a transfer: often none, otherwise drawn at random.
  function automatic int unsigned draw_gap(input bit no_idle);
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Offers one character transfer after a random gap and waits for it to be taken.
  task automatic send_item(input logic [CH_W-1:0] c, input logic closes);
    int unsigned gap;
    gap = draw_gap(sender_no_idle);
    if (gap > 0) begin
      @(negedge clk) char_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_ch.valid     <= 1'b1;
    char_ch.ch        <= c;
    char_ch.token_end <= closes;
    do @(posedge clk); while (!char_ch.ready);
    parser_model.take_char(c, closes);
    chars_sent++;
  endtask

  // Sends a literal token followed by its end transfer.
  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_item(text[i], 1'b0);
    end
    send_item(CH_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Sends a random token: mostly well formed for the base it selects,
  // sometimes with stray bytes and misplaced prefixes mixed in.
  task automatic send_random_token();
    int unsigned       kind;
    int unsigned       len;
    int unsigned       lim;
    int unsigned       d;
    bit                noisy;
    logic [BASE_W-1:0] base;
    logic [CH_W-1:0]   c;
    kind = $urandom_range(0, 7);
    base = cur_base;
    case (kind)
      4: begin
        send_item(CH_DOLLAR, 1'b0);
        base = BASE_HEX;
      end
      5: begin
        send_item(CH_PERCENT, 1'b0);
        base = BASE_BIN;
      end
      6: begin
        send_item(CH_HASH, 1'b0);
        base = BASE_DEC;
      end
      7: begin
        send_item(CH_MINUS, 1'b0);
      end
      default: begin
      end
    endcase
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5);
    noisy = ($urandom_range(0, 4) == 0);
    lim   = (base > DIGIT_SYMBOLS) ? DIGIT_SYMBOLS : int'(base);
    for (int i = 0; i < int'(len); i++) begin
      if (lim == 0 || (noisy && $urandom_range(0, 3) == 0)) begin
        case ($urandom_range(0, 5))
          0:       c = CH_DOLLAR;
          1:       c = CH_MINUS;
          default: c = CH_W'($urandom_range(0, 255));
        endcase
      end else begin
        d = $urandom_range(0, lim - 1);
        if (d < 10) begin
          c = CH_ZERO + CH_W'(d);
        end else begin
          c = CH_LOWER_A + CH_W'(d - 10);
          if ($urandom_range(0, 1) == 1) begin
            c = c & ~CASE_BIT;
          end
        end
      end
      send_item(c, 1'b0);
    end
    send_item(CH_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // One APB transfer at the base register; returns the read data.
  task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_DEFAULT_BASE;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the default base with random upper bits, then reads it back.
  task automatic program_base(input logic [BASE_W-1:0] b);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] rdata;
    wdata = ($urandom & ~APB_DATA_W'(6'h3F)) | APB_DATA_W'(b);
    apb_access(1'b1, wdata, rdata);
    apb_access(1'b0, '0, rdata);
    if (rdata !== APB_DATA_W'(b)) begin
      parser_model.report($sformatf("base register reads %0d after writing %0d", rdata, b));
    end
    parser_model.default_base = b;
    cur_base                  = b;
  endtask

  // Stops offering characters and waits until every owed result has arrived.
  task automatic wait_idle();
    @(negedge clk) char_ch.valid <= 1'b0;
    while (parser_model.due_value.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result receiver: random stalls, one long hold-off on request.
  initial begin : result_sink
    int unsigned hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = draw_gap(receiver_no_idle);
      end
      if (hold > 0) begin
        @(negedge clk) result_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      parser_model.match_result(result_ch.is_number, result_ch.value);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t ns] timeout: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [APB_DATA_W-1:0] rdata;
    logic [BASE_W-1:0]     b;
    int unsigned           first_item;
    int unsigned           settings;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.ch        = '0;
    char_ch.token_end = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    settings          = 1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // The base register comes out of reset at ten.
    apb_access(1'b0, '0, rdata);
    if (rdata !== APB_DATA_W'(BASE_RESET)) begin
      parser_model.report($sformatf("base register reads %0d after reset", rdata));
    end

    // Directed tokens under the reset base.
    send_item(CH_W'($urandom_range(0, 255)), 1'b1);
    send_text("$");
    send_text("-");
    send_text("$fF");
    send_text("%10");
    send_text("#9");
    send_text("-7");
    send_text("1$");
    send_text("Z");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // Random phases, each under its own default base.
    for (int p = 0; p < int'(PHASE_COUNT); p++) begin
      case (p)
        0:       b = 6'd36;
        1:       b = 6'd16;
        2:       b = 6'd2;
        3:       b = 6'd63;
        4:       b = 6'd0;
        5:       b = 6'd1;
        6:       b = 6'd37;
        7:       b = 6'd7;
        default: b = 6'd10;
      endcase
      program_base(b);
      settings++;
      sender_no_idle   = (p == 1 || p == 2);
      receiver_no_idle = (p == 1);
      long_hold_req    = (p == 2);
      first_item       = chars_sent;
      while (chars_sent - first_item < PHASE_ITEMS) begin
        send_random_token();
      end
      // Leave a token open across the next register write; the new base
      // must only apply from the token after it.
      if (p == 3) begin
        send_item(CH_MINUS, 1'b0);
        send_item(CH_LOWER_Z, 1'b0);
        send_item(CH_NINE, 1'b0);
      end
      wait_idle();
    end
    sender_no_idle   = 1'b0;
    receiver_no_idle = 1'b0;

    $display("Run covered %0d character transfers and %0d checked results", chars_sent,
             parser_model.checked);
    $display("over %0d default base settings, with idle gaps and a long result hold-off.",
             settings);
    if (parser_model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pntp_pkg.sv
sv/pntp_char_if.sv
sv/pntp_result_if.sv
sv/pntp_apb_regs.sv
sv/pntp_in_stage.sv
sv/pntp_token_state.sv
sv/prefixed_number_token_parser_top.sv
tb/prefixed_number_token_parser_top_tb.sv
